/* design/fwra_pkg.sv */
// Package for the FP8 weight relayout address generator.
// Holds widths, register codes, pipeline stage types, the division step and the small index functions.
// No dependencies.
package fwra_pkg;

    // Supported matrix size
    localparam int unsigned MAX_ROWS = 4096;
    localparam int unsigned MAX_COLS = 4096;

    // Index and count widths
    localparam int unsigned ROW_W     = $clog2(MAX_ROWS);
    localparam int unsigned COL_W     = $clog2(MAX_COLS);
    localparam int unsigned ROW_CNT_W = ROW_W + 1;
    localparam int unsigned COL_CNT_W = COL_W + 1;

    // Result widths
    localparam int unsigned SRC_W = 33;
    localparam int unsigned DST_W = 24;
    localparam int unsigned OFS_W = 32;

    // APB port
    localparam int unsigned APB_AW = 5;
    localparam int unsigned APB_DW = 32;

    // Tiling geometry: 32-row groups
    localparam int unsigned TILE_LOG  = 5;
    localparam int unsigned TILE_ROWS = 32;
    localparam int unsigned KT_W      = ROW_W - TILE_LOG;
    localparam int unsigned LOW_W     = COL_W + 5;

    // Divider: one step per quotient bit, a few steps per stage
    localparam int unsigned DIV_W       = ROW_CNT_W;
    localparam int unsigned DIV_PER_STG = 4;
    localparam int unsigned DIV_STG     = (DIV_W + DIV_PER_STG - 1) / DIV_PER_STG;

    // Input register, divider stages, two multiply stages, output register
    localparam int unsigned LAT = DIV_STG + 4;

    typedef enum logic [2:0] {
        REG_ROW_COUNT     = 3'd0,
        REG_COLUMN_COUNT  = 3'd1,
        REG_BATCH_ROWS    = 3'd2,
        REG_SWIZZLE_ROWS  = 3'd3,
        REG_TILE_MAJOR    = 3'd4,
        REG_BASE_OFFSET   = 3'd5,
        REG_TENSOR_LENGTH = 3'd6
    } t_reg_idx;

    // One restoring-divider lane: partial remainder and dividend/quotient shifter
    typedef struct packed {
        logic [DIV_W-1:0] rem;
        logic [DIV_W-1:0] dvd;
    } t_div_lane;

    // Payload through the divider stages
    typedef struct packed {
        logic [COL_W-1:0]               n;
        t_div_lane                      jl;
        t_div_lane                      kl;
        logic [SRC_W-1:0]               src;
        logic [LOW_W-1:0]               low;
        logic [ROW_CNT_W+COL_CNT_W-1:0] kn;
        logic                           big;
    } t_dv;

    // Payload after the tile/row index stage
    typedef struct packed {
        logic [DST_W-1:0] a;
        logic [COL_W-1:0] n;
        logic [DIV_W-1:0] rr;
        logic [SRC_W-1:0] src;
        logic             big;
        logic             shape;
        logic             bz;
    } t_e1;

    // Payload after the column multiply stage
    typedef struct packed {
        logic [DST_W-1:0] t;
        logic [DIV_W-1:0] rr;
        logic [SRC_W-1:0] src;
        logic             big;
        logic             shape;
        logic             bz;
    } t_e2;

    // One restoring division step: shift in a dividend bit, subtract when it fits
    function automatic t_div_lane div_step(t_div_lane x, logic [DIV_W-1:0] b);
        logic [DIV_W:0] r;
        r = {x.rem, x.dvd[DIV_W-1]};
        x.dvd = {x.dvd[DIV_W-2:0], 1'b0};
        if (r >= {1'b0, b}) begin
            r = r - {1'b0, b};
            x.dvd[0] = 1'b1;
        end
        x.rem = r[DIV_W-1:0];
        return x;
    endfunction

    // Inverse in-group row permutation: a pure bit shuffle of the low five bits
    function automatic logic [ROW_W-1:0] unswizzle(logic [ROW_W-1:0] j);
        return {j[ROW_W-1:TILE_LOG], j[4], j[2], j[1], j[3], j[0]};
    endfunction

    // Column tile, half, group, lane and byte fields of the packed offset
    function automatic logic [LOW_W-1:0] packed_low(logic [ROW_W-1:0] k,
                                                    logic [COL_W-1:0] c);
        return {c[COL_W-1:7], c[6], c[5:4], c[2:0], k[3:2], c[3], k[4], k[1:0]};
    endfunction

endpackage

/* design/fp8_weight_relayout_address.sv */
// Top level of the FP8 weight relayout address generator: APB registers and pipeline.
// Depends on fwra_pkg.
//
// One item per cycle: each accepted start yields one o_done strobe.
// The depth is the input register, the 13-step row divider (four steps per stage, four
// stages) and three address multiply stages, the last of which drives the outputs.
// busy stays low; the receiver cannot stall.
// Synchronous reset returns the configuration registers to their defaults and clears the valid bits.
module fp8_weight_relayout_address (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [fwra_pkg::ROW_W-1:0]       i_dest_row,
    input  logic [fwra_pkg::COL_W-1:0]       i_dest_col,
    input  logic [fwra_pkg::COL_W-1:0]       i_src_col,
    output logic                             o_done,
    output logic [fwra_pkg::SRC_W-1:0]       o_src_addr,
    output logic [fwra_pkg::DST_W-1:0]       o_dst_addr,
    output logic                             o_shape_error,
    output logic                             o_too_large,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [fwra_pkg::APB_AW-1:0]      paddr,
    input  logic [fwra_pkg::APB_DW-1:0]      pwdata,
    output logic [fwra_pkg::APB_DW-1:0]      prdata,
    output logic                             pready
);
    import fwra_pkg::*;

    // Configuration registers
    logic [ROW_CNT_W-1:0] r_row_count;
    logic [COL_CNT_W-1:0] r_column_count;
    logic [ROW_CNT_W-1:0] r_batch_rows;
    logic                 r_swizzle_rows;
    logic                 r_tile_major;
    logic [OFS_W-1:0]     r_base_offset;
    logic [OFS_W-1:0]     r_tensor_length;

    t_reg_idx             reg_idx;
    logic                 cfg_wr;
    logic [ROW_CNT_W-1:0] w_batch;

    // Pipeline
    logic [LAT-1:0]       r_vld;
    logic [ROW_W-1:0]     r_s0_j;
    logic [ROW_W-1:0]     r_s0_k;
    logic [COL_W-1:0]     r_s0_n;
    logic [COL_W-1:0]     r_s0_c;

    t_dv                  seed;
    t_dv                  dv_in [DIV_STG];
    t_dv                  n_dv  [DIV_STG];
    t_dv                  r_dv  [DIV_STG];
    t_dv                  dv_cur;
    t_dv                  dv_last;

    t_e1                  n_e1;
    t_e1                  r_e1;
    t_e2                  n_e2;
    t_e2                  r_e2;

    logic [SRC_W-1:0]     n_src_addr;
    logic [SRC_W-1:0]     r_src_addr;
    logic [DST_W-1:0]     n_dst_addr;
    logic [DST_W-1:0]     r_dst_addr;
    logic                 n_shape_error;
    logic                 r_shape_error;
    logic                 n_too_large;
    logic                 r_too_large;

    // Products, each at its full width
    logic [KT_W+COL_CNT_W-1:0]              p_ktn;
    logic [ROW_CNT_W+COL_CNT_W-1:0]         p_kn;
    logic [DIV_W+ROW_CNT_W-TILE_LOG-1:0]    p_qb;
    logic [DST_W+COL_CNT_W-1:0]             p_an;
    logic [DST_W+ROW_CNT_W-1:0]             p_tm;
    logic [ROW_CNT_W-1:0]                   e3_mul;
    logic [DIV_W-1:0]                       e3_add;

    // ---------------------------------------------------------------- APB
    assign pready  = 1'b1;
    assign busy    = 1'b0;
    assign reg_idx = t_reg_idx'(paddr[APB_AW-1:2]);
    assign cfg_wr  = psel & penable & pwrite & pready;

    // Write a register on the access beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count     <= ROW_CNT_W'(TILE_ROWS);
            r_column_count  <= COL_CNT_W'(16);
            r_batch_rows    <= '0;
            r_swizzle_rows  <= 1'b0;
            r_tile_major    <= 1'b0;
            r_base_offset   <= '0;
            r_tensor_length <= '0;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_ROW_COUNT:     r_row_count     <= pwdata[ROW_CNT_W-1:0];
                REG_COLUMN_COUNT:  r_column_count  <= pwdata[COL_CNT_W-1:0];
                REG_BATCH_ROWS:    r_batch_rows    <= pwdata[ROW_CNT_W-1:0];
                REG_SWIZZLE_ROWS:  r_swizzle_rows  <= pwdata[0];
                REG_TILE_MAJOR:    r_tile_major    <= pwdata[0];
                REG_BASE_OFFSET:   r_base_offset   <= pwdata[OFS_W-1:0];
                REG_TENSOR_LENGTH: r_tensor_length <= pwdata[OFS_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        case (reg_idx)
            REG_ROW_COUNT:     prdata = APB_DW'(r_row_count);
            REG_COLUMN_COUNT:  prdata = APB_DW'(r_column_count);
            REG_BATCH_ROWS:    prdata = APB_DW'(r_batch_rows);
            REG_SWIZZLE_ROWS:  prdata = APB_DW'(r_swizzle_rows);
            REG_TILE_MAJOR:    prdata = APB_DW'(r_tile_major);
            REG_BASE_OFFSET:   prdata = APB_DW'(r_base_offset);
            REG_TENSOR_LENGTH: prdata = APB_DW'(r_tensor_length);
            default:           prdata = '0;
        endcase
    end

    // Zero batch means the whole row count
    assign w_batch = (r_batch_rows != '0) ? r_batch_rows : r_row_count;

    // ---------------------------------------------------------------- valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], start & ~busy};
        end
    end

    assign o_done = r_vld[LAT-1];

    // ---------------------------------------------------------------- input stage
    // Capture the beat and, when row swizzling is on, un-swizzle the source row
    always_ff @(posedge i_clk) begin
        r_s0_j <= i_dest_row;
        r_s0_k <= r_swizzle_rows ? unswizzle(i_dest_row) : i_dest_row;
        r_s0_n <= i_dest_col;
        r_s0_c <= i_src_col;
    end

    // ---------------------------------------------------------------- divider stages
    assign p_ktn = r_s0_k[ROW_W-1:TILE_LOG] * r_column_count;
    assign p_kn  = r_row_count * r_column_count;

    // Seed both divider lanes and the source-address products
    always_comb begin
        seed.n      = r_s0_n;
        seed.jl.rem = '0;
        seed.jl.dvd = DIV_W'(r_s0_j);
        seed.kl.rem = '0;
        seed.kl.dvd = r_row_count;
        seed.src    = SRC_W'(p_ktn);
        seed.low    = packed_low(r_s0_k, r_s0_c);
        seed.kn     = p_kn;
        seed.big    = 1'b0;
    end

    always_comb begin
        dv_in[0] = seed;
        for (int d = 1; d < DIV_STG; d++) begin
            dv_in[d] = r_dv[d-1];
        end
    end

    // Run a few division steps per stage; finish the source address and the too-large check alongside
    always_comb begin
        dv_cur = seed;
        for (int d = 0; d < DIV_STG; d++) begin
            dv_cur = dv_in[d];
            for (int s = 0; s < DIV_PER_STG; s++) begin
                if (d * DIV_PER_STG + s < DIV_W) begin
                    dv_cur.jl = div_step(dv_cur.jl, w_batch);
                    dv_cur.kl = div_step(dv_cur.kl, w_batch);
                end
            end
            case (d)
                1: begin
                    dv_cur.src = (dv_cur.src << TILE_LOG) + SRC_W'(dv_cur.low);
                    dv_cur.big = (SRC_W'(r_base_offset) + SRC_W'(dv_cur.kn))
                               > SRC_W'(r_tensor_length);
                end
                2: begin
                    dv_cur.src = dv_cur.src + SRC_W'(r_base_offset);
                end
                default: ;
            endcase
            n_dv[d] = dv_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int d = 0; d < DIV_STG; d++) begin
            r_dv[d] <= n_dv[d];
        end
    end

    assign dv_last = r_dv[DIV_STG-1];

    // ---------------------------------------------------------------- tile index stage
    assign p_qb = dv_last.jl.dvd * w_batch[ROW_CNT_W-1:TILE_LOG];

    always_comb begin
        n_e1.a = r_tile_major
               ? DST_W'(p_qb) + DST_W'(dv_last.jl.rem[DIV_W-1:TILE_LOG])
               : DST_W'(dv_last.jl.dvd);
        n_e1.n     = dv_last.n;
        n_e1.rr    = dv_last.jl.rem;
        n_e1.src   = dv_last.src;
        n_e1.big   = dv_last.big;
        n_e1.bz    = (w_batch == '0);
        n_e1.shape = (r_row_count[TILE_LOG-1:0] != '0) || (r_column_count[3:0] != '0)
                  || (w_batch[TILE_LOG-1:0] != '0) || (dv_last.kl.rem != '0)
                  || (w_batch == '0);
    end

    always_ff @(posedge i_clk) begin
        r_e1 <= n_e1;
    end

    // ---------------------------------------------------------------- column stage
    assign p_an = r_e1.a * r_column_count;

    always_comb begin
        n_e2.t     = DST_W'(p_an) + DST_W'(r_e1.n);
        n_e2.rr    = r_e1.rr;
        n_e2.src   = r_e1.src;
        n_e2.big   = r_e1.big;
        n_e2.shape = r_e1.shape;
        n_e2.bz    = r_e1.bz;
    end

    always_ff @(posedge i_clk) begin
        r_e2 <= n_e2;
    end

    // ---------------------------------------------------------------- output stage
    // Scale by 32 and add the in-tile row, or scale by the batch and add the batch row
    assign e3_mul = r_tile_major ? ROW_CNT_W'(TILE_ROWS) : w_batch;
    assign e3_add = r_tile_major ? DIV_W'(r_e2.rr[TILE_LOG-1:0]) : r_e2.rr;
    assign p_tm   = r_e2.t * e3_mul;

    always_comb begin
        n_dst_addr    = r_e2.bz ? '0 : DST_W'(p_tm) + DST_W'(e3_add);
        n_src_addr    = r_e2.src;
        n_shape_error = r_e2.shape;
        n_too_large   = r_e2.big;
    end

    always_ff @(posedge i_clk) begin
        r_src_addr    <= n_src_addr;
        r_dst_addr    <= n_dst_addr;
        r_shape_error <= n_shape_error;
        r_too_large   <= n_too_large;
    end

    assign o_src_addr    = r_src_addr;
    assign o_dst_addr    = r_dst_addr;
    assign o_shape_error = r_shape_error;
    assign o_too_large   = r_too_large;

    // ---------------------------------------------------------------- assertions
    // Every strobe traces back to a start exactly one latency earlier
    a_done_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start, LAT))
        else $error("result strobe without a matching start");

    // With a steady nonzero batch, both divider remainders end below the batch
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[DIV_STG] && (w_batch != '0)
            && (w_batch == $past(w_batch, 1)) && (w_batch == $past(w_batch, 2))
            && (w_batch == $past(w_batch, 3)) && (w_batch == $past(w_batch, 4))
            && (w_batch == $past(w_batch, 5)))
        |-> ((dv_last.jl.rem < w_batch) && (dv_last.kl.rem < w_batch)))
        else $error("divider remainder not below batch");

endmodule
